>>> rtl/hsv2rgb_pkg.sv
`default_nettype none

package hsv2rgb_pkg;

    // channel width and the widest scaled channel before the divide by 60
    localparam int CH_W  = 8;
    localparam int Y_W   = 14;   // 255 * 60 = 15300 fits
    localparam int DIV_W = 27;   // Y_W times the reciprocal below

    // floor(y / 60) ~ (y * 4369) >> 18, low by at most one for y < 2^14
    localparam int          DIV60_SH  = 18;
    localparam logic [12:0] DIV60_MUL = 13'd4369;
    localparam logic [6:0]  SIXTY     = 7'd60;

    // hue sectors of 60 degrees each, red to yellow first
    localparam logic [2:0] SECT_RY = 3'd0;
    localparam logic [2:0] SECT_YG = 3'd1;
    localparam logic [2:0] SECT_GC = 3'd2;
    localparam logic [2:0] SECT_CB = 3'd3;
    localparam logic [2:0] SECT_BM = 3'd4;
    localparam logic [2:0] SECT_MR = 3'd5;

endpackage

`default_nettype wire

>>> rtl/hsv2rgb_div60.sv
`default_nettype none

// Divide by 60 in two parts: reciprocal multiply into a register,
// then one compare and fix-up on the registered product.
module hsv2rgb_div60 (
    input  wire logic                         i_clk,
    input  wire logic                         i_en,
    input  wire logic [hsv2rgb_pkg::Y_W-1:0]  i_y,
    output logic      [hsv2rgb_pkg::CH_W-1:0] o_q
);
    import hsv2rgb_pkg::*;

    logic [Y_W-1:0]   r_y;
    logic [DIV_W-1:0] r_m;
    logic [CH_W-1:0]  w_q0;
    logic [Y_W-1:0]   w_rem;

    // reciprocal product
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_y <= i_y;
            r_m <= DIV_W'(i_y) * DIV_W'(DIV60_MUL);
        end
    end

    // estimate is exact or one short
    always_comb begin
        w_q0  = r_m[DIV60_SH +: CH_W];
        w_rem = r_y - Y_W'(w_q0) * Y_W'(SIXTY);
        o_q   = (w_rem >= Y_W'(SIXTY)) ? w_q0 + CH_W'(1) : w_q0;
    end

endmodule

`default_nettype wire

>>> rtl/hsv_to_rgb_converter.sv
`default_nettype none

// Channel   Direction  tdata fields (lowest bit first)
// s_axis    in         hue_degrees[15:0], saturation[31:16], brightness[47:32]
// m_axis    out        red[7:0], green[15:8], blue[23:16]
//
// Eight register stages: hue offset, hue reciprocal multiply, mod-360 fix-up,
// sector split, channel factors, 255*V products, divide by 60, sector select.
// One word enters per cycle while the output is not stalled.
// Every stage has its own valid bit and loads when it is empty or the next
// stage loads, so bubbles collapse under a stall and nothing is dropped.
// Synchronous active-low reset clears the valid bits only.
module hsv_to_rgb_converter #(
    parameter int FRAC_BITS = 12
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,   // hue_degrees, saturation, brightness
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata    // red, green, blue
);
    import hsv2rgb_pkg::*;

    localparam int NS   = 8;
    localparam int F    = FRAC_BITS;
    localparam int ONE  = 1 << F;
    localparam int SW   = F + 1;        // clamped S and V, 0..ONE
    localparam int VW   = F + 8;        // 255 * V
    localparam int AW   = F + 6;        // 60 * ONE - S * rem
    localparam int PAW  = VW + AW;
    localparam int PCW  = VW + SW;

    localparam logic [15:0] HUE_MUL  = 16'd46603;   // 2^24 / 360, rounded down
    localparam logic [16:0] HUE_OFS  = 17'd33120;   // 92 * 360
    localparam logic [16:0] DEG360   = 17'd360;

    // ---------------- stall control ----------------
    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_en;

    always_comb begin
        w_en[NS-1] = !r_vld[NS-1] || i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    assign o_s_axis_tready = w_en[0];
    assign o_m_axis_tvalid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 0: offset hue, clamp S and V ----------------
    logic [15:0]   w_hue_in, w_sat_in, w_val_in;
    logic [16:0]   w_hsum;
    logic [SW-1:0] n_s, n_v;
    logic [16:0]   r0_u;
    logic [SW-1:0] r0_s, r0_v;

    function automatic logic [SW-1:0] clamp_unit(input logic [15:0] x);
        logic [SW-1:0] res;
        if (x[15]) begin
            res = '0;
        end else if (32'(x[14:0]) > 32'(ONE)) begin
            res = SW'(ONE);
        end else begin
            res = SW'(x[14:0]);
        end
        return res;
    endfunction

    always_comb begin
        w_hue_in = i_s_axis_tdata[15:0];
        w_sat_in = i_s_axis_tdata[31:16];
        w_val_in = i_s_axis_tdata[47:32];
        // sign-extended hue plus a multiple of 360 is never negative
        w_hsum   = {w_hue_in[15], w_hue_in} + HUE_OFS;
        n_s      = clamp_unit(w_sat_in);
        n_v      = clamp_unit(w_val_in);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r0_u <= w_hsum;
            r0_s <= n_s;
            r0_v <= n_v;
        end
    end

    // ---------------- stage 1: reciprocal of 360 ----------------
    logic [16:0]   r1_u;
    logic [31:0]   r1_m;
    logic [SW-1:0] r1_s, r1_v;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r1_u <= r0_u;
            r1_m <= 32'(r0_u) * 32'(HUE_MUL);
            r1_s <= r0_s;
            r1_v <= r0_v;
        end
    end

    // ---------------- stage 2: hue mod 360 ----------------
    logic [7:0]    w_hq;
    logic [16:0]   w_hr;
    logic [8:0]    n_hue;
    logic [8:0]    r2_hue;
    logic [SW-1:0] r2_s, r2_v;

    always_comb begin
        w_hq  = r1_m[31:24];
        w_hr  = r1_u - 17'(w_hq) * DEG360;
        n_hue = (w_hr >= DEG360) ? 9'(w_hr - DEG360) : 9'(w_hr);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r2_hue <= n_hue;
            r2_s   <= r1_s;
            r2_v   <= r1_v;
        end
    end

    // ---------------- stage 3: sector, remainder, 255*V ----------------
    logic [2:0]    n_sect;
    logic [5:0]    n_rem;
    logic [8:0]    w_base;
    logic [2:0]    r3_sect;
    logic [5:0]    r3_rem;
    logic [SW-1:0] r3_s;
    logic [VW-1:0] r3_v255;

    always_comb begin
        if (r2_hue < 9'd60) begin
            n_sect = SECT_RY;
        end else if (r2_hue < 9'd120) begin
            n_sect = SECT_YG;
        end else if (r2_hue < 9'd180) begin
            n_sect = SECT_GC;
        end else if (r2_hue < 9'd240) begin
            n_sect = SECT_CB;
        end else if (r2_hue < 9'd300) begin
            n_sect = SECT_BM;
        end else begin
            n_sect = SECT_MR;
        end
        w_base = 9'(n_sect) * 9'(SIXTY);
        n_rem  = 6'(r2_hue - w_base);
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r3_sect <= n_sect;
            r3_rem  <= n_rem;
            r3_s    <= r2_s;
            r3_v255 <= (VW'(r2_v) << 8) - VW'(r2_v);
        end
    end

    // ---------------- stage 4: channel factors ----------------
    localparam logic [AW-1:0] ONE60 = AW'(60 * ONE);

    logic [AW-1:0] r4_a, r4_b;
    logic [SW-1:0] r4_c;
    logic [VW-1:0] r4_v255;
    logic [2:0]    r4_sect;

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r4_a    <= ONE60 - AW'(r3_s) * AW'(r3_rem);
            r4_b    <= ONE60 - AW'(r3_s) * AW'(SIXTY - 7'(r3_rem));
            r4_c    <= SW'(ONE) - r3_s;
            r4_v255 <= r3_v255;
            r4_sect <= r3_sect;
        end
    end

    // ---------------- stage 5: products with 255*V ----------------
    logic [PAW-1:0]  r5_pa, r5_pb;
    logic [PCW-1:0]  r5_pc;
    logic [CH_W-1:0] r5_v8;
    logic [2:0]      r5_sect;

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r5_pa   <= PAW'(r4_v255) * PAW'(r4_a);
            r5_pb   <= PAW'(r4_v255) * PAW'(r4_b);
            r5_pc   <= PCW'(r4_v255) * PCW'(r4_c);
            r5_v8   <= r4_v255[F +: CH_W];
            r5_sect <= r4_sect;
        end
    end

    // ---------------- stage 6: scale down, divide by 60 ----------------
    logic [CH_W-1:0] w_q, w_t;
    logic [CH_W-1:0] r6_p, r6_v8;
    logic [2:0]      r6_sect;

    hsv2rgb_div60 u_div_q (
        .i_clk (i_clk),
        .i_en  (w_en[6]),
        .i_y   (r5_pa[2*F +: Y_W]),
        .o_q   (w_q)
    );

    hsv2rgb_div60 u_div_t (
        .i_clk (i_clk),
        .i_en  (w_en[6]),
        .i_y   (r5_pb[2*F +: Y_W]),
        .o_q   (w_t)
    );

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r6_p    <= r5_pc[2*F +: CH_W];
            r6_v8   <= r5_v8;
            r6_sect <= r5_sect;
        end
    end

    // ---------------- stage 7: sector select ----------------
    logic [CH_W-1:0] n_r, n_g, n_b;
    logic [CH_W-1:0] r7_r, r7_g, r7_b;

    always_comb begin
        unique case (r6_sect)
            SECT_YG: begin n_r = w_q;   n_g = r6_v8; n_b = r6_p;  end
            SECT_GC: begin n_r = r6_p;  n_g = r6_v8; n_b = w_t;   end
            SECT_CB: begin n_r = r6_p;  n_g = w_q;   n_b = r6_v8; end
            SECT_BM: begin n_r = w_t;   n_g = r6_p;  n_b = r6_v8; end
            SECT_MR: begin n_r = r6_v8; n_g = r6_p;  n_b = w_q;   end
            default: begin n_r = r6_v8; n_g = w_t;   n_b = r6_p;  end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r7_r <= n_r;
            r7_g <= n_g;
            r7_b <= n_b;
        end
    end

    assign o_m_axis_tdata = {r7_b, r7_g, r7_r};

endmodule

`default_nettype wire
